/* design/tis_pkg.sv */
// Shared types and constants for the trie insert/search block.
package tis_pkg;

  localparam int NODE_COUNT_DEF    = 128;
  localparam int ALPHABET_SIZE_DEF = 26;

  localparam int LETTER_W  = 5;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic table_full;
    logic found;
  } result_t;

endpackage

/* design/trie_insert_search.sv */
// Trie insert/search top level: stream ports, walk controller, child table, result register.
//
// Array-based trie over a small alphabet. A word arrives one letter per
// transfer on the slave stream (s_tuser = 0 insert, 1 search; s_tlast on the
// final letter). For each letter the child table entry for (current node,
// letter) is read from the single-port-read RAM as the letter is taken; the
// resolve state then resolves it and writes back a new child or a word-end
// mark. The next letter's address needs the node just read, so letters are
// handled one at a time. Every final letter produces one result word on the
// master stream: found for a search, table_full for an insert that ran out of
// nodes. Results sit in an output register, so the next letter is taken while
// a result is still waiting; a final letter stalls in its resolve cycle only
// if the previous result has not been taken yet. Word-end marks are stored
// beside each child pointer, in the entry of the node's parent, with a
// separate flop for the root. After reset the child table is swept to zero,
// one entry per cycle over all NODE_COUNT * ALPHABET_SIZE entries; s_tready
// stays low until the sweep is done.
module trie_insert_search import tis_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [4:0] letter, [7:5] zero
  input  logic                 s_tuser,  // [0] opcode
  input  logic                 s_tlast,  // last_letter
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // [0] found, [1] table_full, [7:2] zero
);

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic          res_valid, res_ready;
  result_t       res, out_res;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [NW:0]   rd_data, wr_data;

  tis_walk #(
    .NODE_COUNT   (NODE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .NW           (NW),
    .AW           (AW)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_letter(s_tdata[LETTER_W-1:0]),
    .in_last  (s_tlast),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  tis_child_mem #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (NW + 1)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // result register; refills in the same cycle it is drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {(M_TDATA_W - 2)'(0), out_res.table_full, out_res.found};

endmodule

/* design/tis_child_mem.sv */
// Child table RAM: one write port, one read port, registered read data.
module tis_child_mem import tis_pkg::*; #(
  parameter int DEPTH = NODE_COUNT_DEF * ALPHABET_SIZE_DEF,
  parameter int AW    = $clog2(NODE_COUNT_DEF * ALPHABET_SIZE_DEF),
  parameter int DW    = $clog2(NODE_COUNT_DEF) + 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/tis_walk.sv */
// Walk controller: table clear, per-letter read, resolve and write-back.
module tis_walk import tis_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int NW            = $clog2(NODE_COUNT),
  parameter int AW            = $clog2(NODE_COUNT * ALPHABET_SIZE)
) (
  input  logic                clk,
  input  logic                rst,
  // letter input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic                in_last,
  // result toward the output register
  output logic                res_valid,
  input  logic                res_ready,
  output result_t             res,
  // child table port; entry = {word end mark of child, child node}
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [NW:0]         rd_data,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [NW:0]         wr_data
);

  localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int FW    = $clog2(NODE_COUNT + 1);

  state_t        state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [NW-1:0] cur_node, cur_node_next;
  logic          cur_mark, cur_mark_next;
  logic          root_mark, root_mark_next;
  logic [AW-1:0] parent_slot, parent_slot_next;
  logic          miss, miss_next;
  logic          full, full_next;
  logic [FW-1:0] next_free, next_free_next;

  // letter held across the resolve cycle
  logic          op_q, last_q, live_q;
  logic [AW-1:0] slot_q;

  logic          accept, live, ins_last, go;
  logic [AW-1:0] slot;
  logic [NW-1:0] rd_child;
  logic          rd_mark;

  assign accept   = in_valid && in_ready;
  assign live     = !miss && !full && (32'(in_letter) < ALPHABET_SIZE);
  assign slot     = AW'(AW'(cur_node) * AW'(ALPHABET_SIZE) + AW'(in_letter));
  assign rd_en    = accept && live;
  assign rd_addr  = slot;
  assign rd_child = rd_data[NW-1:0];
  assign rd_mark  = rd_data[NW];
  assign ins_last = (op_q == OP_INSERT) && last_q;
  // a final letter waits until the output register can take its result
  assign go       = !last_q || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      cur_node    <= '0;
      cur_mark    <= 1'b0;
      root_mark   <= 1'b0;
      parent_slot <= '0;
      miss        <= 1'b0;
      full        <= 1'b0;
      next_free   <= FW'(1);
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      cur_node    <= cur_node_next;
      cur_mark    <= cur_mark_next;
      root_mark   <= root_mark_next;
      parent_slot <= parent_slot_next;
      miss        <= miss_next;
      full        <= full_next;
      next_free   <= next_free_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= in_op;
      last_q <= in_last;
      live_q <= live;
      slot_q <= slot;
    end
  end

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    cur_node_next    = cur_node;
    cur_mark_next    = cur_mark;
    root_mark_next   = root_mark;
    parent_slot_next = parent_slot;
    miss_next        = miss;
    full_next        = full;
    next_free_next   = next_free;
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    res              = '0;
    wr_en            = 1'b0;
    wr_addr          = slot_q;
    wr_data          = '0;

    unique case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (live_q) begin
          if (rd_child != '0) begin
            cur_node_next    = rd_child;
            cur_mark_next    = rd_mark;
            parent_slot_next = slot_q;
            if (ins_last) begin
              wr_en   = go;
              wr_data = {1'b1, rd_child};
            end
          end else if (op_q == OP_SEARCH) begin
            miss_next = 1'b1;
          end else if (next_free == FW'(NODE_COUNT)) begin
            full_next = 1'b1;
          end else begin
            wr_en            = go;
            wr_data          = {ins_last, next_free[NW-1:0]};
            cur_node_next    = next_free[NW-1:0];
            cur_mark_next    = ins_last;
            parent_slot_next = slot_q;
            next_free_next   = next_free + FW'(1);
          end
        end else if (ins_last && !miss && !full) begin
          // out-of-range final letter: mark the node already reached
          if (cur_node == '0) begin
            root_mark_next = 1'b1;
          end else begin
            wr_en   = go;
            wr_addr = parent_slot;
            wr_data = {1'b1, cur_node};
          end
        end

        res.found      = (op_q == OP_SEARCH) && !miss_next && !full_next &&
                         ((cur_node_next == '0) ? root_mark : cur_mark_next);
        res.table_full = (op_q == OP_INSERT) && full_next;
        res_valid      = last_q;

        if (last_q) begin
          cur_node_next = '0;
          miss_next     = 1'b0;
          full_next     = 1'b0;
        end

        if (go) begin
          state_next = ST_IDLE;
        end else begin
          // hold everything while the result waits
          cur_node_next    = cur_node;
          cur_mark_next    = cur_mark;
          root_mark_next   = root_mark;
          parent_slot_next = parent_slot;
          miss_next        = miss;
          full_next        = full;
          next_free_next   = next_free;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* design/tis_checker.sv */
// Port-level checker for the trie insert/search block, bound to the top level.
module tis_checker import tis_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a letter occupies the block for its resolve cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("s_tready high right after a letter was taken");

  // a fresh result comes from a final letter that was taken and then resolved
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result without a final letter");

  // found and table_full never both set, and the upper bits are zero
  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[M_TDATA_W-1:2] == '0))
    else $error("malformed result word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind trie_insert_search tis_checker u_tis_checker (.*);
